### sv/bpoa_pkg.sv
// ----------------------------------------------------------------------------
// bpoa_pkg
// Shared types and constants of the phase overlap accumulator.
// ----------------------------------------------------------------------------
package bpoa_pkg;

	// inverse cordic gain, Q1.30
	localparam logic signed [63:0] GainInvQ30 = 64'sd652032874;

	// arctangent table in units of 2^-32 turn
	function automatic logic [31:0] atan_turn(input logic [4:0] i);
		logic [31:0] r;
		case (i)
			5'd0: r = 32'h20000000;
			5'd1: r = 32'h12E4051E;
			5'd2: r = 32'h09FB385B;
			5'd3: r = 32'h051111D4;
			5'd4: r = 32'h028B0D43;
			5'd5: r = 32'h0145D7E1;
			5'd6: r = 32'h00A2F61E;
			5'd7: r = 32'h00517C55;
			5'd8: r = 32'h0028BE53;
			5'd9: r = 32'h00145F2F;
			5'd10: r = 32'h000A2F98;
			5'd11: r = 32'h000517CC;
			5'd12: r = 32'h00028BE6;
			5'd13: r = 32'h000145F3;
			5'd14: r = 32'h0000A2FA;
			5'd15: r = 32'h0000517D;
			5'd16: r = 32'h000028BE;
			5'd17: r = 32'h0000145F;
			5'd18: r = 32'h00000A30;
			5'd19: r = 32'h00000518;
			5'd20: r = 32'h0000028C;
			5'd21: r = 32'h00000146;
			5'd22: r = 32'h000000A3;
			5'd23: r = 32'h00000051;
			5'd24: r = 32'h00000029;
			5'd25: r = 32'h00000014;
			5'd26: r = 32'h0000000A;
			5'd27: r = 32'h00000005;
			5'd28: r = 32'h00000003;
			5'd29: r = 32'h00000001;
			5'd30: r = 32'h00000001;
			default: r = 32'h00000000;
		endcase
		return r;
	endfunction

	// cordic result for one angle
	typedef struct packed {
		logic signed [63:0] c;
		logic signed [63:0] s;
	} cs_t;

endpackage

### sv/bpoa_cordic.sv
// ----------------------------------------------------------------------------
// bpoa_cordic
// Iterative cordic: cosine and sine of a 32-bit turn angle, one step a cycle.
// ----------------------------------------------------------------------------
module bpoa_cordic #(
	parameter int CORDIC_STEPS = 24
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  logic [31:0]       turn,
	output logic              done,
	output bpoa_pkg::cs_t     result
);

	logic              busy_q;
	logic [4:0]        step_q;
	logic [1:0]        quad_q;
	logic signed [63:0] x_q, y_q, z_q;
	logic signed [63:0] dx, dy, za;

	// shifted terms of the current step (arithmetic shift is floor)
	always_comb begin
		dx = y_q >>> step_q;
		dy = x_q >>> step_q;
		za = {32'd0, bpoa_pkg::atan_turn(step_q)};
	end

	// step control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			step_q <= '0;
			done   <= 1'b0;
		end else begin
			done <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				step_q <= '0;
			end else if (busy_q) begin
				if (32'(step_q) == CORDIC_STEPS - 1) begin
					busy_q <= 1'b0;
					done   <= 1'b1;
				end
				step_q <= step_q + 5'd1;
			end
		end
	end

	// rotation datapath
	always_ff @(posedge clk) begin
		if (start) begin
			quad_q <= turn[31:30];
			x_q    <= bpoa_pkg::GainInvQ30;
			y_q    <= '0;
			z_q    <= {34'd0, turn[29:0]};
		end else if (busy_q) begin
			if (!z_q[63]) begin
				x_q <= x_q - dx;
				y_q <= y_q + dy;
				z_q <= z_q - za;
			end else begin
				x_q <= x_q + dx;
				y_q <= y_q - dy;
				z_q <= z_q + za;
			end
		end
	end

	// quadrant turn
	always_comb begin
		case (quad_q)
			2'd0: begin result.c = x_q;  result.s = y_q;  end
			2'd1: begin result.c = -y_q; result.s = x_q;  end
			2'd2: begin result.c = -x_q; result.s = -y_q; end
			default: begin result.c = y_q; result.s = -x_q; end
		endcase
	end

endmodule

### sv/bloch_phase_overlap_accumulator_unit.sv
// ----------------------------------------------------------------------------
// bloch_phase_overlap_accumulator_unit
// Accumulates one Bloch-phase overlap term per request into a complex sum.
// ----------------------------------------------------------------------------
// Input channel: in_valid / in_stall with one port per term field. A request
// is taken when in_valid is high and in_stall low; in_stall stays high while
// a term is being worked on.
// Output channel: out_valid / out_stall carrying sum_re, sum_im, saturated;
// a result appears only for terms flagged last_term, after which the
// accumulator is cleared.
// Each term runs through one shared 33x32 multiplier (a 64x32 product is
// two passes) and an iterative cordic, used twice.
// Noncollinear mode adds the down-pair products to those of collinear
// mode; a last term also passes through the output state.
// The result sits in an output register; a stalled receiver only holds
// back the next last term, not the earlier ones.
// spin_mode is to be written via cfg_we / cfg_wdata only while the block
// is idle; the block itself does not enforce this.
// Reset clears the accumulator, the saturation flag and spin_mode.
// ----------------------------------------------------------------------------
module bloch_phase_overlap_accumulator_unit #(
	parameter int CORDIC_STEPS = 24
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_we,
	input  logic               cfg_wdata,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic [63:0]        first_a_up,
	input  logic [63:0]        second_b_up,
	input  logic [63:0]        first_b_up,
	input  logic [63:0]        second_a_up,
	input  logic [63:0]        first_a_down,
	input  logic [63:0]        second_b_down,
	input  logic [63:0]        first_b_down,
	input  logic [63:0]        second_a_down,
	input  logic [63:0]        overlap,
	input  logic [31:0]        turn_forward,
	input  logic [31:0]        turn_backward,
	input  logic               last_term,
	output logic               out_valid,
	input  logic               out_stall,
	output logic signed [63:0] sum_re,
	output logic signed [63:0] sum_im,
	output logic               saturated
);

	localparam logic [3:0] StIdle = 4'd0;
	localparam logic [3:0] StConj = 4'd1;
	localparam logic [3:0] StCord = 4'd2;
	localparam logic [3:0] StCwait = 4'd3;
	localparam logic [3:0] StRot = 4'd4;
	localparam logic [3:0] StOvl = 4'd5;
	localparam logic [3:0] StAcc = 4'd6;
	localparam logic [3:0] StOut = 4'd7;

	logic [3:0]  state_q;
	logic        spin_q;
	logic [63:0] fa_q [4];
	logic [63:0] sb_q [4];
	logic [63:0] ovl_q;
	logic [31:0] tf_q, tb_q;
	logic        last_q;
	logic [4:0]  cnt_q;
	logic        pass_q;      // 0: forward product, 1: backward product
	logic signed [63:0] p_re_q [2];
	logic signed [63:0] p_im_q [2];
	logic signed [63:0] h_re_q, h_im_q;
	logic signed [63:0] t_re_q, t_im_q;
	logic signed [63:0] acc_re_q, acc_im_q;
	logic        clip_q;
	logic        cord_start, cord_done;
	bpoa_pkg::cs_t cs;
	bpoa_pkg::cs_t cs_q;

	// shared multiplier: signed 64 x signed 32 through a 33x32 core in two passes
	logic signed [63:0] ma;
	logic signed [31:0] mb;
	logic [5:0]         msh;
	logic signed [32:0] ma_part;
	logic               ma_hi;
	logic signed [65:0] pp;
	logic signed [95:0] prod_q;
	logic signed [63:0] mul_res;

	assign ma_part = ma_hi ? $signed({ma[63], ma[63:32]}) : $signed({1'b0, ma[31:0]});

	// operand select: cnt_q[4:1] picks the product, cnt_q[0] the half
	always_comb begin
		logic [1:0] pi;
		logic [63:0] w1, w2;
		ma  = '0;
		mb  = '0;
		msh = 6'd30;
		pi  = cnt_q[4:3];
		w1  = fa_q[pi];
		w2  = sb_q[pi];
		case (state_q)
			StConj: begin
				case (cnt_q[2:1])
					2'd0: begin ma = 64'($signed(w1[63:32])); mb = w2[63:32]; end
					2'd1: begin ma = 64'($signed(w1[31:0]));  mb = w2[31:0];  end
					2'd2: begin ma = 64'($signed(w1[63:32])); mb = w2[31:0];  end
					default: begin ma = 64'($signed(w1[31:0])); mb = w2[63:32]; end
				endcase
			end
			StRot: begin
				case (cnt_q[2:1])
					2'd0: begin ma = p_re_q[pass_q]; mb = cs_q.c[31:0]; end
					2'd1: begin ma = p_im_q[pass_q]; mb = cs_q.s[31:0]; end
					2'd2: begin ma = p_im_q[pass_q]; mb = cs_q.c[31:0]; end
					default: begin ma = p_re_q[pass_q]; mb = cs_q.s[31:0]; end
				endcase
			end
			StOvl: begin
				msh = 6'd31;
				case (cnt_q[2:1])
					2'd0: begin ma = h_re_q; mb = ovl_q[63:32]; end
					2'd1: begin ma = h_im_q; mb = ovl_q[31:0];  end
					2'd2: begin ma = h_re_q; mb = ovl_q[31:0];  end
					default: begin ma = h_im_q; mb = ovl_q[63:32]; end
				endcase
			end
			default: ;
		endcase
	end

	assign ma_hi = cnt_q[0];
	assign pp    = 66'(ma_part) * 66'(mb);

	// floor of the rescaled product (operands stay far inside range)
	assign mul_res = 64'(prod_q >>> msh);

	logic signed [63:0] mres_q;

	// cordic instance shared by both angles
	bpoa_cordic #(.CORDIC_STEPS(CORDIC_STEPS)) u_cordic (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (cord_start),
		.turn   (pass_q ? tb_q : tf_q),
		.done   (cord_done),
		.result (cs)
	);

	assign cord_start = (state_q == StCord);
	assign in_stall   = (state_q != StIdle);

	// saturating adds
	logic signed [64:0] sr, si;
	assign sr = 65'(acc_re_q) + 65'(t_re_q);
	assign si = 65'(acc_im_q) + 65'(t_im_q);

	// sequencer and datapath
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= StIdle;
			spin_q    <= 1'b0;
			acc_re_q  <= '0;
			acc_im_q  <= '0;
			clip_q    <= 1'b0;
			out_valid <= 1'b0;
			cnt_q     <= '0;
			pass_q    <= 1'b0;
		end else begin
			if (cfg_we) spin_q <= cfg_wdata;
			if (out_valid && !out_stall && state_q != StOut) out_valid <= 1'b0;
			case (state_q)
				StIdle: begin
					if (in_valid) begin
						fa_q[0] <= first_a_up;   sb_q[0] <= second_b_up;
						fa_q[1] <= first_b_up;   sb_q[1] <= second_a_up;
						fa_q[2] <= first_a_down; sb_q[2] <= second_b_down;
						fa_q[3] <= first_b_down; sb_q[3] <= second_a_down;
						ovl_q   <= overlap;
						tf_q    <= turn_forward;
						tb_q    <= turn_backward;
						last_q  <= last_term;
						cnt_q   <= '0;
						state_q <= StConj;
					end
				end
				// eight up-pair products in two halves each; eight more down-pair ones only if noncollinear
				StConj: begin
					if (cnt_q == 5'd15 && !spin_q) begin
						cnt_q <= '0; pass_q <= 1'b0; state_q <= StCord;
					end else begin
						cnt_q <= cnt_q + 5'd1;
						if (cnt_q == 5'd31) begin
							pass_q <= 1'b0; state_q <= StCord;
						end
					end
				end
				StCord: state_q <= StCwait;
				StCwait: begin
					if (cord_done) begin
						cs_q    <= cs;
						cnt_q   <= '0;
						state_q <= StRot;
					end
				end
				StRot: begin
					if (cnt_q == 5'd9) begin
						cnt_q <= '0;
						if (!pass_q) begin
							pass_q <= 1'b1; state_q <= StCord;
						end else state_q <= StOvl;
					end else cnt_q <= cnt_q + 5'd1;
				end
				StOvl: begin
					cnt_q <= cnt_q + 5'd1;
					if (cnt_q == 5'd9) state_q <= StAcc;
				end
				StAcc: begin
					logic signed [63:0] nr, ni;
					logic cr, ci;
					cr = sr[64] != sr[63];
					ci = si[64] != si[63];
					nr = cr ? (sr[64] ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}}) : sr[63:0];
					ni = ci ? (si[64] ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}}) : si[63:0];
					if (last_q) begin
						state_q <= StOut;
						acc_re_q <= nr; acc_im_q <= ni; clip_q <= clip_q | cr | ci;
					end else begin
						acc_re_q <= nr; acc_im_q <= ni; clip_q <= clip_q | cr | ci;
						state_q <= StIdle;
					end
				end
				StOut: begin
					if (!out_valid || !out_stall) begin
						sum_re    <= acc_re_q;
						sum_im    <= acc_im_q;
						saturated <= clip_q;
						out_valid <= 1'b1;
						acc_re_q  <= '0;
						acc_im_q  <= '0;
						clip_q    <= 1'b0;
						state_q   <= StIdle;
					end
				end
				default: state_q <= StIdle;
			endcase
		end
	end

	// multiply: even count builds low half, odd adds high half then floor-shifts
	always_ff @(posedge clk) begin
		if (!cnt_q[0]) prod_q <= 96'(pp);
		else           prod_q <= prod_q + (96'(pp) <<< 32);
	end

	// collect finished products; a product is complete in the cycle after its odd step
	logic [4:0]  cprev_q;
	logic [3:0]  sprev_q;
	logic        vprev_q;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vprev_q <= 1'b0;
			cprev_q <= '0;
			sprev_q <= StIdle;
		end else begin
			vprev_q <= cnt_q[0] && (state_q == StConj || state_q == StRot ||
				state_q == StOvl);
			cprev_q <= cnt_q;
			sprev_q <= state_q;
		end
	end

	// conjugate sums start from zero while waiting for a request
	always_ff @(posedge clk) begin
		if (state_q == StIdle) begin
			p_re_q[0] <= '0; p_im_q[0] <= '0;
			p_re_q[1] <= '0; p_im_q[1] <= '0;
		end else if (vprev_q) begin
			case (sprev_q)
				StConj: begin
					case (cprev_q[2:1])
						2'd0: p_re_q[cprev_q[3]] <= p_re_q[cprev_q[3]] + mul_res;
						2'd1: p_re_q[cprev_q[3]] <= p_re_q[cprev_q[3]] + mul_res;
						2'd2: p_im_q[cprev_q[3]] <= p_im_q[cprev_q[3]] + mul_res;
						default: p_im_q[cprev_q[3]] <= p_im_q[cprev_q[3]] - mul_res;
					endcase
				end
				StRot, StCord: begin
					case (cprev_q[2:1])
						2'd0: mres_q <= mul_res;
						2'd1: if (!pass_q || sprev_q == StCord) h_re_q <= mres_q - mul_res;
							else h_re_q <= h_re_q + mres_q - mul_res;
						2'd2: mres_q <= mul_res;
						default: if (!pass_q || sprev_q == StCord)
								h_im_q <= mres_q + mul_res;
							else h_im_q <= h_im_q + mres_q + mul_res;
					endcase
				end
				StOvl, StAcc: begin
					case (cprev_q[2:1])
						2'd0: mres_q <= mul_res;
						2'd1: t_re_q <= mres_q - mul_res;
						2'd2: mres_q <= mul_res;
						default: t_im_q <= mres_q + mul_res;
					endcase
				end
				default: ;
			endcase
		end
	end

endmodule
